// File: src/material_id_remap_search_unit_defines.svh
// Assertion macros shared by the material id remap search unit.
`ifndef MATERIAL_ID_REMAP_SEARCH_UNIT_DEFINES_SVH
`define MATERIAL_ID_REMAP_SEARCH_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// A property checked at every clock edge outside reset.
`define MIRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must be followed by a consequence in the next cycle.
`define MIRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MIRS_ASSERT(lbl, prop, msg)
`define MIRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/mirs_pkg.sv
// Types and constants shared by the material id remap search unit.
package mirs_pkg;

  // Fixed field widths of the channels.
  localparam int OPCODE_W  = 2;
  localparam int INST_ID_W = 10;
  localparam int ID_W      = 32;
  localparam int INDEX_W   = 12;
  // Width wide enough to hold any table address or count in range.
  localparam int ADDR_EXT_W = 17;

  // Input opcodes.
  localparam logic [OPCODE_W-1:0] OP_LOOKUP    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WR_INST   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_WR_START  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_WR_PAIR   = 2'd3;

  // Commands passed from the front part to the back part.
  typedef enum logic [2:0] {
    CMD_LOOKUP,
    CMD_PASS,
    CMD_WR_INST,
    CMD_WR_START,
    CMD_WR_PAIR,
    CMD_NOP
  } mirs_cmd_kind_t;

  typedef struct packed {
    mirs_cmd_kind_t          kind;
    logic [INDEX_W-1:0]      index;
    logic [ID_W-1:0]         key;
    logic [ID_W-1:0]         data;
    logic                    flag;
  } mirs_cmd_t;

  // Status of the back part, seen by the front part.
  typedef struct packed {
    logic init_done;
    logic busy;
  } mirs_status_t;

  // Back part sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INST,
    ST_LIST,
    ST_END,
    ST_SEARCH,
    ST_DONE
  } mirs_state_t;

endpackage

// File: src/mirs_if.sv
// Valid/ready channel interfaces for input items and result items.
interface mirs_in_if;
  import mirs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [INST_ID_W-1:0] instance_id;
  logic [ID_W-1:0]      material_id;
  logic [INDEX_W-1:0]   table_index;
  logic [ID_W-1:0]      value_a;
  logic [ID_W-1:0]      value_b;
  logic                 no_remap;

  modport source (output valid, opcode, instance_id, material_id, table_index,
                  value_a, value_b, no_remap, input ready);
  modport sink (input valid, opcode, instance_id, material_id, table_index,
                value_a, value_b, no_remap, output ready);
endinterface

interface mirs_out_if;
  import mirs_pkg::*;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] remapped_id;
  logic            matched;

  modport source (output valid, remapped_id, matched, input ready);
  modport sink (input valid, remapped_id, matched, output ready);
endinterface

// File: src/mirs_front.sv
// Front part: accepts input items, checks ranges and turns them into commands.
module mirs_front #(
  parameter int INSTANCE_COUNT = 1024,
  parameter int LIST_COUNT     = 256,
  parameter int PAIR_COUNT     = 4096
) (
  mirs_in_if.sink                in_chan,
  input  mirs_pkg::mirs_status_t status,
  output logic                   push_valid,
  output mirs_pkg::mirs_cmd_t    push_cmd,
  input  logic                   push_ready
);
  import mirs_pkg::*;

  localparam int EW = ADDR_EXT_W;

  logic [EW-1:0] inst_ext;
  logic [EW-1:0] index_ext;

  // Items are taken only once the instance table has been cleared.
  assign in_chan.ready = push_ready && status.init_done;
  assign push_valid    = in_chan.valid && status.init_done;

  assign inst_ext  = EW'(in_chan.instance_id);
  assign index_ext = EW'(in_chan.table_index);

  // Classify the item and resolve range checks and saturation here.
  always_comb begin
    push_cmd.kind  = CMD_NOP;
    push_cmd.index = in_chan.table_index;
    push_cmd.key   = '0;
    push_cmd.data  = '0;
    push_cmd.flag  = 1'b0;
    case (in_chan.opcode)
      OP_LOOKUP: begin
        push_cmd.index = INDEX_W'(in_chan.instance_id);
        push_cmd.key   = in_chan.material_id;
        if (inst_ext < EW'(INSTANCE_COUNT)) begin
          push_cmd.kind = CMD_LOOKUP;
        end else begin
          push_cmd.kind = CMD_PASS;
        end
      end
      OP_WR_INST: begin
        if (index_ext < EW'(INSTANCE_COUNT)) begin
          push_cmd.kind = CMD_WR_INST;
        end
        push_cmd.data = in_chan.value_a;
        push_cmd.flag = !in_chan.no_remap && (in_chan.value_a < ID_W'(LIST_COUNT));
      end
      OP_WR_START: begin
        if (index_ext <= EW'(LIST_COUNT)) begin
          push_cmd.kind = CMD_WR_START;
        end
        push_cmd.data = (in_chan.value_a > ID_W'(PAIR_COUNT)) ?
                        ID_W'(PAIR_COUNT) : in_chan.value_a;
      end
      OP_WR_PAIR: begin
        if (index_ext < EW'(PAIR_COUNT)) begin
          push_cmd.kind = CMD_WR_PAIR;
        end
        push_cmd.key  = in_chan.value_a;
        push_cmd.data = in_chan.value_b;
      end
      default: begin
        push_cmd.kind = CMD_NOP;
      end
    endcase
  end

endmodule

// File: src/mirs_queue.sv
// Two-entry command queue between the front and back parts.
module mirs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  mirs_pkg::mirs_cmd_t push_cmd,
  output logic                push_ready,
  output logic                pop_valid,
  output mirs_pkg::mirs_cmd_t pop_cmd,
  input  logic                pop
);
  import mirs_pkg::*;

  mirs_cmd_t  entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/mirs_back.sv
// Back part: holds the three tables, runs table writes and the binary search.
module mirs_back #(
  parameter int INSTANCE_COUNT = 1024,
  parameter int LIST_COUNT     = 256,
  parameter int PAIR_COUNT     = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  input  mirs_pkg::mirs_cmd_t    pop_cmd,
  output logic                   pop,
  output mirs_pkg::mirs_status_t status,
  mirs_out_if.source             out_chan
);
  import mirs_pkg::*;

  localparam int EW  = ADDR_EXT_W;
  localparam int IW  = (INSTANCE_COUNT > 1) ? $clog2(INSTANCE_COUNT) : 1;
  localparam int LW  = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int SAW = $clog2(LIST_COUNT + 1);
  localparam int SW  = $clog2(PAIR_COUNT + 1);
  localparam int PW  = $clog2(PAIR_COUNT);

  // Table storage: has-list bit above the list number, starts, and pairs.
  logic [LW:0]          inst_mem  [INSTANCE_COUNT];
  logic [SW-1:0]        start_mem [LIST_COUNT + 1];
  logic [2*ID_W-1:0]    pair_mem  [PAIR_COUNT];

  logic                 inst_we;
  logic [IW-1:0]        inst_waddr, inst_raddr;
  logic [LW:0]          inst_wdata, inst_q;
  logic                 start_we;
  logic [SAW-1:0]       start_waddr, start_raddr;
  logic [SW-1:0]        start_wdata, start_q;
  logic                 pair_we;
  logic [PW-1:0]        pair_waddr, pair_raddr;
  logic [2*ID_W-1:0]    pair_wdata, pair_q;

  mirs_state_t          state_r, state_nxt;
  logic [IW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [LW-1:0]        lst_r, lst_nxt;
  logic [ID_W-1:0]      key_r, key_nxt;
  logic [SW-1:0]        lo_r, lo_nxt;
  logic [SW-1:0]        hi_r, hi_nxt;
  logic [SW-1:0]        end_r, end_nxt;
  logic [SW-1:0]        m_r, m_nxt;
  logic                 final_r, final_nxt;
  logic [ID_W-1:0]      res_id_r, res_id_nxt;
  logic                 res_match_r, res_match_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic                 out_match_r, out_match_nxt;

  logic [EW-1:0]        idx_ext;
  logic                 out_free;
  logic [ID_W-1:0]      pair_from, pair_to;
  logic [SW-1:0]        lo_s, hi_s, mid_s, mid_e;

  assign idx_ext   = EW'(pop_cmd.index);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign pair_from = pair_q[2*ID_W-1:ID_W];
  assign pair_to   = pair_q[ID_W-1:0];

  assign status.init_done = (state_r != ST_CLEAR);
  assign status.busy      = (state_r != ST_CLEAR) && (state_r != ST_IDLE);

  assign out_chan.valid       = out_valid_r;
  assign out_chan.remapped_id = out_id_r;
  assign out_chan.matched     = out_match_r;

  // One search step: narrow the range on the pair read last cycle.
  always_comb begin
    if (pair_from >= key_r) begin
      lo_s = lo_r;
      hi_s = m_r;
    end else begin
      lo_s = m_r + SW'(1);
      hi_s = hi_r;
    end
    mid_s = lo_s + ((hi_s - lo_s) >> 1);
    mid_e = lo_r + ((start_q - lo_r) >> 1);
  end

  // Sequencer: next state, memory ports and result.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    lst_nxt       = lst_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    end_nxt       = end_r;
    m_nxt         = m_r;
    final_nxt     = final_r;
    res_id_nxt    = res_id_r;
    res_match_nxt = res_match_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_id_nxt    = out_id_r;
    out_match_nxt = out_match_r;
    pop           = 1'b0;
    inst_we       = 1'b0;
    inst_waddr    = idx_ext[IW-1:0];
    inst_wdata    = '0;
    inst_raddr    = '0;
    start_we      = 1'b0;
    start_waddr   = idx_ext[SAW-1:0];
    start_wdata   = pop_cmd.data[SW-1:0];
    start_raddr   = '0;
    pair_we       = 1'b0;
    pair_waddr    = idx_ext[PW-1:0];
    pair_wdata    = {pop_cmd.key, pop_cmd.data};
    pair_raddr    = '0;

    case (state_r)
      ST_CLEAR: begin
        // Mark every instance as having no list, one entry a cycle.
        inst_we     = 1'b1;
        inst_waddr  = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == IW'(INSTANCE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_valid) begin
          pop           = 1'b1;
          res_id_nxt    = '0;
          res_match_nxt = 1'b0;
          state_nxt     = ST_DONE;
          case (pop_cmd.kind)
            CMD_LOOKUP: begin
              inst_raddr = idx_ext[IW-1:0];
              key_nxt    = pop_cmd.key;
              state_nxt  = ST_INST;
            end
            CMD_PASS: begin
              res_id_nxt = pop_cmd.key;
            end
            CMD_WR_INST: begin
              inst_we    = 1'b1;
              inst_wdata = pop_cmd.flag ? {1'b1, pop_cmd.data[LW-1:0]} : '0;
            end
            CMD_WR_START: begin
              start_we = 1'b1;
            end
            CMD_WR_PAIR: begin
              pair_we = 1'b1;
            end
            default: begin
              res_id_nxt = '0;
            end
          endcase
        end
      end
      ST_INST: begin
        // Instance entry is back: fetch the start of its list.
        lst_nxt     = inst_q[LW-1:0];
        start_raddr = SAW'(inst_q[LW-1:0]);
        if (inst_q[LW]) begin
          state_nxt = ST_LIST;
        end else begin
          res_id_nxt = key_r;
          state_nxt  = ST_DONE;
        end
      end
      ST_LIST: begin
        // Start is back: fetch the next list's start, which ends this one.
        lo_nxt      = start_q;
        start_raddr = SAW'(lst_r) + SAW'(1);
        state_nxt   = ST_END;
      end
      ST_END: begin
        end_nxt   = start_q;
        hi_nxt    = start_q;
        final_nxt = 1'b0;
        if (start_q <= lo_r) begin
          res_id_nxt = key_r;
          state_nxt  = ST_DONE;
        end else begin
          m_nxt      = mid_e;
          pair_raddr = mid_e[PW-1:0];
          state_nxt  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (final_r) begin
          // The pair at the lower bound decides between a match and a miss.
          if ((lo_r < end_r) && (pair_from == key_r)) begin
            res_id_nxt    = pair_to;
            res_match_nxt = 1'b1;
          end else begin
            res_id_nxt = key_r;
          end
          state_nxt = ST_DONE;
        end else begin
          lo_nxt = lo_s;
          hi_nxt = hi_s;
          if (lo_s < hi_s) begin
            m_nxt      = mid_s;
            pair_raddr = mid_s[PW-1:0];
          end else begin
            final_nxt  = 1'b1;
            pair_raddr = lo_s[PW-1:0];
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_match_nxt = res_match_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    lst_r       <= lst_nxt;
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    end_r       <= end_nxt;
    m_r         <= m_nxt;
    final_r     <= final_nxt;
    res_id_r    <= res_id_nxt;
    res_match_r <= res_match_nxt;
    out_id_r    <= out_id_nxt;
    out_match_r <= out_match_nxt;
  end

  // Instance table with registered read.
  always_ff @(posedge clk) begin
    if (inst_we) begin
      inst_mem[inst_waddr] <= inst_wdata;
    end
    inst_q <= inst_mem[inst_raddr];
  end

  // List start table with registered read.
  always_ff @(posedge clk) begin
    if (start_we) begin
      start_mem[start_waddr] <= start_wdata;
    end
    start_q <= start_mem[start_raddr];
  end

  // Pair table with registered read.
  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_waddr] <= pair_wdata;
    end
    pair_q <= pair_mem[pair_raddr];
  end

endmodule

// File: src/material_id_remap_search_unit.sv
// Top level of the material id remap search unit.
//
// Items arrive on in_chan (valid/ready); one result per item leaves on out_chan.
// Opcode 0 looks a material id up in its instance's sorted remap list; opcodes
// 1 to 3 write the instance table, the list start table and the pair table,
// and return a zero result.
// A front part classifies each item and range-checks it into a two-entry queue;
// a back part holds the tables and executes the commands in order. A command
// reaches the back part in the cycle after its transfer at the earliest.
// A table write is done by the back part from its idle state. A lookup makes
// three dependent setup reads (instance entry, list start, list end), one
// pair-table read per search step, since each step's address comes from the pair
// read before it, and a last read that decides the match. A lookup on an instance
// with no list ends after the instance entry read, one on an empty list after
// the list end read.
// The output register holds a finished result while the receiver stalls; the
// front keeps filling the queue until it is full, then drops in_chan.ready.
// After reset the back part clears the instance table, one entry a cycle;
// in_chan.ready stays low until that pass is over.
module material_id_remap_search_unit #(
  parameter int INSTANCE_COUNT = 1024,
  parameter int LIST_COUNT     = 256,
  parameter int PAIR_COUNT     = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  mirs_in_if.sink     in_chan,
  mirs_out_if.source  out_chan
);
  import mirs_pkg::*;
  `include "material_id_remap_search_unit_defines.svh"

  logic         push_valid;
  logic         push_ready;
  mirs_cmd_t    push_cmd;
  logic         pop_valid;
  logic         pop;
  mirs_cmd_t    pop_cmd;
  mirs_status_t status;

  // Front part: classification.
  mirs_front #(
    .INSTANCE_COUNT (INSTANCE_COUNT),
    .LIST_COUNT     (LIST_COUNT),
    .PAIR_COUNT     (PAIR_COUNT)
  ) u_front (
    .in_chan    (in_chan),
    .status     (status),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // Command queue between the two parts.
  mirs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  // Back part: tables and search.
  mirs_back #(
    .INSTANCE_COUNT (INSTANCE_COUNT),
    .LIST_COUNT     (LIST_COUNT),
    .PAIR_COUNT     (PAIR_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .status    (status),
    .out_chan  (out_chan)
  );

  // No transfer is taken while the instance table is still being cleared.
  `MIRS_ASSERT(a_no_accept_in_clear, !status.init_done |-> !in_chan.ready, "accept during clear")
  // The back part only takes a command that the queue holds.
  `MIRS_ASSERT(a_pop_when_valid, pop |-> pop_valid, "pop from empty queue")
  // A new result is only loaded by a command in progress.
  `MIRS_ASSERT(a_result_from_cmd, $rose(out_chan.valid) |-> $past(status.busy), "stray result")
  // Every accepted item lands in the queue.
  `MIRS_ASSERT_NEXT(a_accept_fills, in_chan.valid && in_chan.ready, pop_valid, "item lost")

endmodule

// File: bench/tb.sv
// Self-checking testbench for the material id remap search unit.
`timescale 1ns / 1ps

module tb;
  import mirs_pkg::*;

  localparam int N_INST = 1024;
  localparam int N_LIST = 256;
  localparam int N_PAIR = 4096;
  // Number of items left in the backlog below which random idle bursts and stalls stop.
  localparam int TAIL_ITEMS = 120;
  localparam int WANTED_ITEMS = 1450;

  typedef struct packed {
    logic [OPCODE_W-1:0]  opcode;
    logic [INST_ID_W-1:0] instance_id;
    logic [ID_W-1:0]      material_id;
    logic [INDEX_W-1:0]   table_index;
    logic [ID_W-1:0]      value_a;
    logic [ID_W-1:0]      value_b;
    logic                 no_remap;
    logic                 hold_for_drain;
  } remap_req_t;

  typedef struct packed {
    logic [ID_W-1:0] remapped_id;
    logic            matched;
  } remap_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mirs_in_if  in_chan ();
  mirs_out_if out_chan ();

  material_id_remap_search_unit #(
    .INSTANCE_COUNT(N_INST),
    .LIST_COUNT(N_LIST),
    .PAIR_COUNT(N_PAIR)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  always #5 clk = ~clk;

  // Driven registers, known from time zero.
  remap_req_t cur_req = '0;
  logic drv_valid = 1'b0;
  logic ack_ready = 1'b0;

  assign in_chan.valid       = drv_valid;
  assign in_chan.opcode      = cur_req.opcode;
  assign in_chan.instance_id = cur_req.instance_id;
  assign in_chan.material_id = cur_req.material_id;
  assign in_chan.table_index = cur_req.table_index;
  assign in_chan.value_a     = cur_req.value_a;
  assign in_chan.value_b     = cur_req.value_b;
  assign in_chan.no_remap    = cur_req.no_remap;
  assign out_chan.ready      = ack_ready;

  remap_req_t remap_requests[$];
  remap_res_t remap_answers[$];
  int accepted_items = 0;
  int total_items = 0;
  int useful_items = 0;
  int fail_count = 0;
  int gap_left = 0;
  bit calm_tail = 1'b0;

  // Predicted contents of the block's tables.
  bit             map_has  [N_INST];
  bit [7:0]       map_list [N_INST];
  bit [12:0]      start_tab[N_LIST+1];
  bit [ID_W-1:0]  from_tab [N_PAIR];
  bit [ID_W-1:0]  to_tab   [N_PAIR];

  // What the stimulus has written so far, so that no lookup reads an unwritten entry.
  int plan_list    [N_INST];
  int plan_start   [N_LIST+1];
  bit plan_start_ok[N_LIST+1];
  bit plan_pair_ok [N_PAIR];
  int mapped_pool[$];

  // Applies one accepted item to the predicted tables and returns its result.
  function automatic remap_res_t remap_predict(remap_req_t r);
    remap_res_t res;
    int l, lo, hi, fin, mid, idx;
    res.remapped_id = '0;
    res.matched = 1'b0;
    idx = int'(r.table_index);
    case (r.opcode)
      OP_LOOKUP: begin
        res.remapped_id = r.material_id;
        if (map_has[r.instance_id]) begin
          l = int'(map_list[r.instance_id]);
          lo = int'(start_tab[l]);
          fin = int'(start_tab[l+1]);
          hi = fin;
          // Lower-bound search over the list's from ids.
          if (fin > lo) begin
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (from_tab[mid] >= r.material_id) hi = mid;
              else lo = mid + 1;
            end
            if (lo < fin && from_tab[lo] == r.material_id) begin
              res.remapped_id = to_tab[lo];
              res.matched = 1'b1;
            end
          end
        end
      end
      OP_WR_INST: begin
        if (idx < N_INST) begin
          if (r.no_remap || r.value_a >= N_LIST) begin
            map_has[idx] = 1'b0;
            map_list[idx] = '0;
          end else begin
            map_has[idx] = 1'b1;
            map_list[idx] = r.value_a[7:0];
          end
        end
      end
      OP_WR_START: begin
        if (idx <= N_LIST)
          start_tab[idx] = (r.value_a > N_PAIR) ? 13'(N_PAIR) : r.value_a[12:0];
      end
      OP_WR_PAIR: begin
        from_tab[idx] = r.value_a;
        to_tab[idx] = r.value_b;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic remap_req_t rand_req();
    remap_req_t r;
    r.opcode = OPCODE_W'($urandom);
    r.instance_id = INST_ID_W'($urandom);
    r.material_id = $urandom;
    r.table_index = INDEX_W'($urandom);
    r.value_a = $urandom;
    r.value_b = $urandom;
    r.no_remap = 1'($urandom);
    r.hold_for_drain = 1'b0;
    return r;
  endfunction

  // Queues an item and records what it writes.
  function automatic void add_request(remap_req_t r);
    int idx;
    idx = int'(r.table_index);
    remap_requests.push_back(r);
    case (r.opcode)
      OP_LOOKUP: useful_items++;
      OP_WR_INST: begin
        if (idx < N_INST) begin
          useful_items++;
          if (r.no_remap || r.value_a >= N_LIST) begin
            plan_list[idx] = -1;
          end else begin
            plan_list[idx] = int'(r.value_a);
            mapped_pool.push_back(idx);
          end
        end
      end
      OP_WR_START: begin
        if (idx <= N_LIST) begin
          useful_items++;
          plan_start[idx] = (r.value_a > N_PAIR) ? N_PAIR : int'(r.value_a);
          plan_start_ok[idx] = 1'b1;
        end
      end
      default: begin
        useful_items++;
        plan_pair_ok[idx] = 1'b1;
      end
    endcase
  endfunction

  function automatic void put_write(logic [OPCODE_W-1:0] op, int idx, bit [ID_W-1:0] va,
                                    bit [ID_W-1:0] vb, bit nr, bit hold);
    remap_req_t r;
    r = rand_req();
    r.opcode = op;
    r.table_index = INDEX_W'(idx);
    r.value_a = va;
    r.value_b = vb;
    r.no_remap = nr;
    r.hold_for_drain = hold;
    add_request(r);
  endfunction

  // True when a lookup on this instance reads only written entries.
  function automatic bit lookup_safe(int inst);
    int l, s, e, i;
    l = plan_list[inst];
    if (l < 0) return 1'b1;
    if (!plan_start_ok[l] || !plan_start_ok[l+1]) return 1'b0;
    s = plan_start[l];
    e = plan_start[l+1];
    for (i = s; i < e; i++)
      if (!plan_pair_ok[i]) return 1'b0;
    return 1'b1;
  endfunction

  // A lookup whose list is not fully written is preceded by unmapping the instance.
  function automatic void emit_lookup(int inst, bit [ID_W-1:0] mat);
    remap_req_t r;
    if (!lookup_safe(inst)) put_write(OP_WR_INST, inst, $urandom, $urandom, 1'b1, 1'b0);
    r = rand_req();
    r.opcode = OP_LOOKUP;
    r.instance_id = INST_ID_W'(inst);
    r.material_id = mat;
    add_request(r);
  endfunction

  // Builds one sorted list, maps a few instances onto it and looks ids up in it.
  function automatic void build_list(bit hold);
    bit [ID_W-1:0] keys[$];
    int picks[$];
    int l, base, n, shape, i, j, cnt, inst;
    bit [ID_W-1:0] key, end_val;
    shape = $urandom_range(0, 19);
    if (shape == 3) l = N_LIST - 1;
    else if ($urandom_range(0, 3) == 0) l = $urandom_range(0, N_LIST - 1);
    else l = $urandom_range(0, 15);
    base = l * 16;
    if (shape == 0) n = 0;
    else if (shape == 1 || shape == 3) n = 16;
    else n = $urandom_range(1, 9);
    end_val = ID_W'(base + n);
    // Reversed bounds, or an end above the pair table that saturates.
    if (shape == 2 && base > 0) end_val = ID_W'(base - $urandom_range(1, base));
    else if (shape == 3) end_val = $urandom_range(32'hFFFF_FFFF, N_PAIR);
    put_write(OP_WR_START, l, ID_W'(base), $urandom, 1'($urandom), hold);
    put_write(OP_WR_START, l + 1, end_val, $urandom, 1'($urandom), 1'b0);
    for (i = 0; i < n; i++) begin
      j = $urandom_range(0, 11);
      key = (j == 0) ? '0 : (j == 1) ? '1 : ID_W'($urandom);
      keys.push_back(key);
    end
    keys.sort();
    for (i = 1; i < n; i++)
      if ($urandom_range(0, 7) == 0) keys[i] = keys[i-1];
    for (i = 0; i < n; i++)
      put_write(OP_WR_PAIR, base + i, keys[i], $urandom, 1'($urandom), 1'b0);
    cnt = $urandom_range(1, 3);
    for (i = 0; i < cnt; i++) begin
      inst = $urandom_range(0, N_INST - 1);
      picks.push_back(inst);
      put_write(OP_WR_INST, inst, ID_W'(l), $urandom, 1'b0, 1'b0);
    end
    cnt = $urandom_range(3, 10);
    for (i = 0; i < cnt; i++) begin
      inst = picks[$urandom_range(0, picks.size() - 1)];
      if (n == 0) begin
        key = $urandom;
      end else begin
        key = keys[$urandom_range(0, n - 1)];
        case ($urandom_range(0, 9))
          5: key = key - 1;
          6: key = key + 1;
          7: key = '0;
          8: key = '1;
          9: key = $urandom;
          default: begin
          end
        endcase
      end
      emit_lookup(inst, key);
    end
  endfunction

  // A short run of loosely formed items with random fields, some drawn within range.
  function automatic void add_noise();
    remap_req_t r;
    int cnt, i, inst;
    cnt = $urandom_range(1, 4);
    for (i = 0; i < cnt; i++) begin
      r = rand_req();
      case ($urandom_range(0, 3))
        0: begin
          if (mapped_pool.size() != 0 && $urandom_range(0, 1))
            inst = mapped_pool[$urandom_range(0, mapped_pool.size() - 1)];
          else
            inst = int'(r.instance_id);
          emit_lookup(inst, r.material_id);
        end
        1: begin
          r.opcode = OP_WR_INST;
          if ($urandom_range(0, 1)) r.table_index = INDEX_W'($urandom_range(0, N_INST - 1));
          if ($urandom_range(0, 1)) r.value_a = ID_W'($urandom_range(0, N_LIST - 1));
          add_request(r);
        end
        2: begin
          r.opcode = OP_WR_START;
          if ($urandom_range(0, 1)) r.table_index = INDEX_W'($urandom_range(0, N_LIST));
          if ($urandom_range(0, 1)) r.value_a = ID_W'($urandom_range(0, N_PAIR + 100));
          add_request(r);
        end
        default: begin
          r.opcode = OP_WR_PAIR;
          add_request(r);
        end
      endcase
    end
  endfunction

  // Sender: offers queued items, with idle bursts and pauses for a full drain.
  always @(posedge clk) begin : item_driver
    bit send;
    send = 1'b0;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_chan.ready) begin
        remap_answers.push_back(remap_predict(cur_req));
        accepted_items++;
      end
      if (!drv_valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (remap_requests.size() != 0) begin
          if (remap_requests[0].hold_for_drain && remap_answers.size() != 0) begin
            // Wait here until every outstanding result has come back.
          end else if (!calm_tail && ((accepted_items / 128) % 4 != 3) &&
                       $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 13);
          end else begin
            cur_req <= remap_requests.pop_front();
            send = 1'b1;
          end
        end
        drv_valid <= send;
      end
      calm_tail <= remap_requests.size() < TAIL_ITEMS;
    end
  end

  // Receiver: checks each result transfer and stalls at random, once for a long stretch.
  always @(posedge clk) begin : result_checker
    remap_res_t want;
    bit nxt;
    static int hold_left = 0;
    static int stall_left = 0;
    static int results_seen = 0;
    static bit long_hold_done = 1'b0;
    nxt = 1'b1;
    if (!rst_n) begin
      ack_ready <= 1'b0;
    end else begin
      if (out_chan.valid && ack_ready) begin
        results_seen++;
        if (remap_answers.size() == 0) begin
          $error("unexpected result: remapped_id %h matched %b",
                 out_chan.remapped_id, out_chan.matched);
          fail_count++;
        end else begin
          want = remap_answers.pop_front();
          if (out_chan.remapped_id !== want.remapped_id) begin
            $error("remapped_id: expected %h, got %h", want.remapped_id, out_chan.remapped_id);
            fail_count++;
          end
          if (out_chan.matched !== want.matched) begin
            $error("matched: expected %b, got %b", want.matched, out_chan.matched);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (!long_hold_done && results_seen >= 300) begin
        // Long hold-off so that the block fills and stops taking items.
        long_hold_done = 1'b1;
        hold_left = 400;
        nxt = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 13);
        nxt = 1'b0;
      end
      ack_ready <= nxt;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run_control
    int i, nbuild;
    nbuild = 0;
    for (i = 0; i < N_INST; i++) plan_list[i] = -1;

    // Pass-through before any list exists, and writes to indexes out of range.
    emit_lookup(0, '0);
    emit_lookup(N_INST - 1, '1);
    put_write(OP_WR_INST, 4095, '0, $urandom, 1'b0, 1'b0);
    put_write(OP_WR_START, N_LIST + 1, '0, $urandom, 1'b0, 1'b0);
    // List 0 holds three pairs, the top one at the largest id.
    put_write(OP_WR_START, 0, '0, $urandom, 1'b0, 1'b0);
    put_write(OP_WR_START, 1, 32'd3, $urandom, 1'b0, 1'b0);
    put_write(OP_WR_PAIR, 0, 32'd5, 32'h50, 1'b0, 1'b0);
    put_write(OP_WR_PAIR, 1, 32'd10, 32'hDEAD_BEEF, 1'b0, 1'b0);
    put_write(OP_WR_PAIR, 2, '1, '0, 1'b0, 1'b0);
    put_write(OP_WR_INST, 5, '0, $urandom, 1'b0, 1'b0);
    put_write(OP_WR_INST, N_INST - 1, '0, $urandom, 1'b0, 1'b0);
    // A list number out of range and the no-remap flag both leave the instance unmapped.
    put_write(OP_WR_INST, 6, 32'd300, $urandom, 1'b0, 1'b0);
    put_write(OP_WR_INST, 7, '0, $urandom, 1'b1, 1'b0);
    emit_lookup(5, 32'd5);
    emit_lookup(N_INST - 1, '1);
    emit_lookup(5, 32'd7);
    emit_lookup(5, '0);
    emit_lookup(6, 32'd5);
    emit_lookup(7, 32'd5);
    // List 1 ends below its start, so it is empty.
    put_write(OP_WR_START, 2, 32'd1, $urandom, 1'b0, 1'b0);
    put_write(OP_WR_INST, 8, 32'd1, $urandom, 1'b0, 1'b0);
    emit_lookup(8, 32'd3);
    // The last list ends beyond the pair table and is cut at its end.
    put_write(OP_WR_START, N_LIST - 1, N_PAIR - 2, $urandom, 1'b0, 1'b0);
    put_write(OP_WR_PAIR, N_PAIR - 2, '0, 32'd1, 1'b0, 1'b0);
    put_write(OP_WR_PAIR, N_PAIR - 1, 32'hFFFF_FFFE, 32'd2, 1'b0, 1'b0);
    put_write(OP_WR_START, N_LIST, '1, $urandom, 1'b0, 1'b0);
    put_write(OP_WR_INST, 9, N_LIST - 1, $urandom, 1'b0, 1'b0);
    emit_lookup(9, 32'hFFFF_FFFE);
    emit_lookup(9, '0);

    // Mostly well-formed list builds, with some noise in between.
    while (useful_items < WANTED_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        add_noise();
      end else begin
        build_list(nbuild % 10 == 0);
        nbuild++;
      end
    end
    total_items = remap_requests.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_items < total_items) @(posedge clk);
    while (remap_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("material_id_remap_search_unit: match");
    else
      $display("material_id_remap_search_unit: mismatch");
    $finish;
  end

  // Guard against a hang.
  initial begin : watchdog
    #4_000_000;
    $display("material_id_remap_search_unit: mismatch");
    $finish;
  end

endmodule
